@@ hw/rtl/srsa_pkg.sv @@
package srsa_pkg;

   localparam int ACC_DEPTH_DEFAULT = 1024;

   localparam int ACTIVE_COLS_WIDTH = 11;
   localparam logic [ACTIVE_COLS_WIDTH-1:0] ACTIVE_COLS_RESET = 11'd1024;

   localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
   localparam logic [1:0] CMD_READ       = 2'd1;
   localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_SKIPPED = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [7:0]  scale;
      logic [15:0]        col_index;
      logic signed [7:0]  value;
      logic               last_in_row;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic lookup;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/sparse_row_scaled_accumulate.sv @@
// A result is registered at the commit that writes its entry; the item passes
// idle (take the item), lookup (read the entry) and commit (write it), and commit
// waits while an earlier result is held by rsp_stall. No new item is taken until commit is done.
// Reset is synchronous; afterwards the accumulator is zeroed one entry per cycle,
// all ACC_DEPTH entries, with req_stall high. active_cols resets to 1024.
module sparse_row_scaled_accumulate
   import srsa_pkg::*;
#(
   parameter int ACC_DEPTH = ACC_DEPTH_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  req_item_type                 req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rsp_item_type                 rsp_item,
   input  logic                         csr_write_enable,
   input  logic [ACTIVE_COLS_WIDTH-1:0] csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   srsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   srsa_datapath #(
      .ACC_DEPTH (ACC_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status)
   );

endmodule

@@ hw/rtl/srsa_ctrl.sv @@
module srsa_ctrl
   import srsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (dp_status.clear_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (dp_status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      dp_cmd.clear_step = (state_ff == ST_CLEAR);
      dp_cmd.load_item  = (state_ff == ST_IDLE) && req_valid;
      dp_cmd.lookup     = (state_ff == ST_LOOKUP);
      dp_cmd.commit     = (state_ff == ST_COMMIT) && dp_status.out_free;
   end

endmodule

@@ hw/rtl/srsa_datapath.sv @@
module srsa_datapath
   import srsa_pkg::*;
#(
   parameter int ACC_DEPTH = ACC_DEPTH_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  req_item_type                 req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rsp_item_type                 rsp_item,
   input  logic                         csr_write_enable,
   input  logic [ACTIVE_COLS_WIDTH-1:0] csr_write_data,
   input  dp_cmd_type                   dp_cmd,
   output dp_status_type                dp_status
);

   localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

   logic [31:0]                  mem [ACC_DEPTH];

   logic [ACTIVE_COLS_WIDTH-1:0] active_cols_ff;
   logic [AW-1:0]                clear_addr_ff;
   req_item_type                 item_ff;
   logic signed [15:0]           product_ff;
   logic [31:0]                  read_data_ff;
   logic                         col_ok_ff;
   logic                         row_failed_ff;
   logic                         row_failed_in;
   logic                         rsp_valid_ff;
   rsp_item_type                 rsp_item_ff;
   rsp_item_type                 rsp_item_in;

   logic                         wr_enable;
   logic [AW-1:0]                wr_addr;
   logic [31:0]                  wr_data;
   logic [AW-1:0]                item_addr;
   logic                         col_ok;

   assign item_addr = item_ff.col_index[AW-1:0];
   assign col_ok    = ({1'b0, item_ff.col_index} < 17'(ACC_DEPTH))
                      && (item_ff.col_index < 16'(active_cols_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= ACTIVE_COLS_RESET;
      end else if (csr_write_enable) begin
         active_cols_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (dp_cmd.clear_step && !dp_status.clear_done) begin
         clear_addr_ff <= clear_addr_ff + AW'(1);
      end
   end

   assign dp_status.clear_done = (clear_addr_ff == AW'(ACC_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         item_ff <= req_item;
      end
      if (dp_cmd.lookup) begin
         product_ff   <= 16'(item_ff.scale * item_ff.value);
         read_data_ff <= mem[item_addr];
         col_ok_ff    <= col_ok;
      end
   end

   always_comb begin
      rsp_item_in   = '{status: STATUS_OK, read_value: '0};
      row_failed_in = row_failed_ff;
      wr_enable     = 1'b0;
      wr_addr       = item_addr;
      wr_data       = '0;
      if (dp_cmd.clear_step) begin
         wr_enable = 1'b1;
         wr_addr   = clear_addr_ff;
      end else if (dp_cmd.commit) begin
         unique case (item_ff.command)
            CMD_ACCUMULATE: begin
               if (row_failed_ff) begin
                  rsp_item_in.status = STATUS_SKIPPED;
               end else if (!col_ok_ff) begin
                  rsp_item_in.status = STATUS_INVALID;
                  row_failed_in      = 1'b1;
               end else begin
                  wr_enable = 1'b1;
                  wr_data   = read_data_ff + 32'(product_ff);
               end
               if (item_ff.last_in_row) begin
                  row_failed_in = 1'b0;
               end
            end
            CMD_READ, CMD_READ_CLEAR: begin
               if (!col_ok_ff) begin
                  rsp_item_in.status = STATUS_INVALID;
               end else begin
                  rsp_item_in.read_value = read_data_ff;
                  wr_enable = (item_ff.command == CMD_READ_CLEAR);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_failed_ff <= 1'b0;
      end else begin
         row_failed_ff <= row_failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item           = rsp_item_ff;

endmodule

@@ verif/row_accumulate_checker.sv @@
`timescale 1ns / 100ps
module row_accumulate_checker
   import srsa_pkg::*;
#(
   parameter int ACC_DEPTH = ACC_DEPTH_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  req_item_type                 req_item,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  rsp_item_type                 rsp_item,
   input  logic                         csr_write_enable,
   input  logic [ACTIVE_COLS_WIDTH-1:0] csr_write_data,
   output int                           mismatch_count,
   output int                           outstanding
);

   logic [31:0]                  acc_entries [ACC_DEPTH];
   logic                         row_failed;
   logic [ACTIVE_COLS_WIDTH-1:0] active_cols;
   rsp_item_type                 predicted_readouts [$];

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic rsp_item_type scale_and_accumulate(input req_item_type item);
      rsp_item_type       result;
      int unsigned        col_limit;
      logic               in_range;
      logic signed [31:0] product;
      result.status = STATUS_OK;
      result.read_value = '0;
      col_limit = (active_cols > ACC_DEPTH) ? ACC_DEPTH : active_cols;
      in_range = item.col_index < col_limit;
      case (item.command)
         CMD_ACCUMULATE: begin
            if (row_failed) begin
               result.status = STATUS_SKIPPED;
            end else if (!in_range) begin
               result.status = STATUS_INVALID;
               row_failed = 1'b1;
            end else begin
               product = $signed(item.scale) * $signed(item.value);
               acc_entries[item.col_index] = acc_entries[item.col_index] + product;
            end
            if (item.last_in_row) begin
               row_failed = 1'b0;
            end
         end
         CMD_READ, CMD_READ_CLEAR: begin
            if (!in_range) begin
               result.status = STATUS_INVALID;
            end else begin
               result.read_value = acc_entries[item.col_index];
               if (item.command == CMD_READ_CLEAR) begin
                  acc_entries[item.col_index] = '0;
               end
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_item_type wanted;
      if (reset) begin
         foreach (acc_entries[i]) begin
            acc_entries[i] = '0;
         end
         row_failed = 1'b0;
         active_cols = ACTIVE_COLS_RESET;
         predicted_readouts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_readouts.size() == 0) begin
               report_mismatch($sformatf("unexpected result: status %0d read_value %0d",
                  rsp_item.status, rsp_item.read_value));
            end else begin
               wanted = predicted_readouts.pop_front();
               if (rsp_item.status !== wanted.status) begin
                  report_mismatch($sformatf("status is %0d, predicted %0d",
                     rsp_item.status, wanted.status));
               end
               if (rsp_item.read_value !== wanted.read_value) begin
                  report_mismatch($sformatf("read_value is %0d, predicted %0d",
                     rsp_item.read_value, wanted.read_value));
               end
            end
         end
         if (csr_write_enable) begin
            active_cols = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            predicted_readouts.push_back(scale_and_accumulate(req_item));
         end
      end
      outstanding = predicted_readouts.size();
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
module testbench
   import srsa_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int LONG_HOLD_AT = 120;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   req_item_type                 req_item;
   logic                         rsp_valid;
   logic                         rsp_stall;
   rsp_item_type                 rsp_item;
   logic                         csr_write_enable;
   logic [ACTIVE_COLS_WIDTH-1:0] csr_write_data;
   int                           mismatch_count;
   int                           outstanding;
   int unsigned                  col_limit;
   int                           sender_burst;
   int                           receiver_burst;
   int                           idle_cycles = 0;

   sparse_row_scaled_accumulate dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   row_accumulate_checker accum_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_item_type make_item(input logic [1:0] command,
      input logic [7:0] scale, input logic [15:0] col_index, input logic [7:0] value,
      input logic last_in_row);
      req_item_type item;
      item.command = command;
      item.scale = scale;
      item.col_index = col_index;
      item.value = value;
      item.last_in_row = last_in_row;
      return item;
   endfunction

   function automatic logic [15:0] pick_column(input bit want_valid);
      if (want_valid && col_limit > 0) begin
         if ($urandom_range(0, 1)) begin
            return 16'($urandom_range(0, (col_limit > 8 ? 8 : col_limit) - 1));
         end
         return 16'($urandom_range(0, col_limit - 1));
      end
      if ($urandom_range(0, 1)) begin
         return 16'($urandom_range(col_limit, col_limit + 2));
      end
      return 16'($urandom_range(col_limit, 65535));
   endfunction

   // Entered at a falling edge; returns at the falling edge after the item is taken.
   task automatic issue_request(input req_item_type item);
      int gap;
      if (sender_burst > 0) begin
         gap = 0;
         sender_burst--;
      end else if ($urandom_range(0, 9) == 0) begin
         gap = 0;
         sender_burst = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic set_active_cols(input logic [ACTIVE_COLS_WIDTH-1:0] cols);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cols;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      col_limit = (cols > ACC_DEPTH_DEFAULT) ? ACC_DEPTH_DEFAULT : cols;
   endtask

   // Mostly well-formed rows, some with a bad column and some left unterminated,
   // mixed with reads, read-and-clears and the odd unused command.
   task automatic send_random_traffic(input int count);
      int sent;
      int pick;
      int row_len;
      int bad_pos;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            row_len = $urandom_range(1, 6);
            bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(0, row_len - 1) : -1;
            for (int i = 0; i < row_len; i++) begin
               issue_request(make_item(CMD_ACCUMULATE, 8'($urandom),
                  pick_column(i != bad_pos), 8'($urandom),
                  (i == row_len - 1) && ($urandom_range(0, 9) != 0)));
               sent++;
            end
         end else if (pick < 96) begin
            issue_request(make_item($urandom_range(0, 1) ? CMD_READ : CMD_READ_CLEAR,
               8'($urandom), pick_column($urandom_range(0, 7) != 0), 8'($urandom),
               1'($urandom_range(0, 1))));
            sent++;
         end else begin
            issue_request(make_item(CMD_UNUSED, 8'($urandom), 16'($urandom),
               8'($urandom), 1'($urandom_range(0, 1))));
            sent++;
         end
      end
   endtask

   initial begin
      int hold;
      int taken;
      rsp_stall = 1'b0;
      taken = 0;
      receiver_burst = 0;
      @(negedge clock);
      forever begin
         if (taken == LONG_HOLD_AT) begin
            hold = LONG_HOLD_CYCLES;
         end else if (receiver_burst > 0) begin
            hold = 0;
            receiver_burst--;
         end else if ($urandom_range(0, 9) == 0) begin
            hold = 0;
            receiver_burst = $urandom_range(10, 40);
         end else begin
            hold = $urandom_range(0, 19);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      logic [ACTIVE_COLS_WIDTH-1:0] phase_cols [7];
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      sender_burst = 0;
      col_limit = ACC_DEPTH_DEFAULT;
      phase_cols = '{11'd1, 11'd2047, 11'd0, 11'd37, 11'd1024, 11'd1023, 11'd0};
      phase_cols[6] = 11'($urandom_range(1, 2047));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_request(make_item(CMD_ACCUMULATE, 8'h80, 16'd0, 8'h80, 1'b1));
      issue_request(make_item(CMD_ACCUMULATE, 8'h7f, 16'd1023, 8'h80, 1'b0));
      issue_request(make_item(CMD_ACCUMULATE, 8'h7f, 16'd1023, 8'h7f, 1'b1));
      issue_request(make_item(CMD_READ, 8'h55, 16'd0, 8'haa, 1'b1));
      issue_request(make_item(CMD_READ_CLEAR, 8'haa, 16'd1023, 8'h55, 1'b0));
      issue_request(make_item(CMD_READ, 8'h00, 16'd1023, 8'h00, 1'b0));
      issue_request(make_item(CMD_ACCUMULATE, 8'h03, 16'd1024, 8'h04, 1'b0));
      issue_request(make_item(CMD_ACCUMULATE, 8'h05, 16'd5, 8'h06, 1'b0));
      issue_request(make_item(CMD_READ, 8'h11, 16'd5, 8'h22, 1'b1));
      issue_request(make_item(CMD_ACCUMULATE, 8'h07, 16'hffff, 8'h08, 1'b1));
      issue_request(make_item(CMD_ACCUMULATE, 8'h01, 16'd5, 8'h01, 1'b0));
      issue_request(make_item(CMD_ACCUMULATE, 8'hff, 16'd5, 8'h7f, 1'b1));
      issue_request(make_item(CMD_READ, 8'h01, 16'hffff, 8'h01, 1'b0));
      issue_request(make_item(CMD_READ_CLEAR, 8'h01, 16'd1024, 8'h01, 1'b0));
      issue_request(make_item(CMD_UNUSED, 8'hff, 16'hffff, 8'hff, 1'b1));
      issue_request(make_item(CMD_ACCUMULATE, 8'h09, 16'd2000, 8'h0a, 1'b1));
      issue_request(make_item(CMD_ACCUMULATE, 8'h80, 16'd5, 8'h7f, 1'b1));
      issue_request(make_item(CMD_READ_CLEAR, 8'h00, 16'd5, 8'h00, 1'b0));
      issue_request(make_item(CMD_READ, 8'h00, 16'd0, 8'h00, 1'b0));

      foreach (phase_cols[p]) begin
         set_active_cols(phase_cols[p]);
         send_random_traffic(RANDOM_PER_PHASE);
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
